FILE: hw/rtl/bsl_pkg.sv
package bsl_pkg;

	localparam int CHAN_W      = 5;
	localparam int STAMP_W     = 32;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int MAX_RESULTS = 32;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int DEF_CHANNELS = 32;

	localparam logic [CFG_W-1:0] RST_MIN_PRESS  = CFG_W'(1);
	localparam logic [CFG_W-1:0] RST_ACTION_GAP = CFG_W'(50);
	localparam logic [CFG_W-1:0] RST_LONG_PRESS = CFG_W'(1000);

	localparam logic [CFG_IDX_W-1:0] REG_MIN_PRESS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTION_GAP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd2;

	localparam logic OP_LEVEL = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	localparam logic LEVEL_PRESSED = 1'b0;

	typedef struct packed {
		logic              op;
		logic [CHAN_W-1:0] channel;
		logic              level;
	} item_t;

	typedef struct packed {
		logic [CHAN_W-1:0] button;
		logic              is_long;
		logic              last;
	} result_t;

	typedef struct packed {
		logic load;
		logic eval;
		logic advance;
		logic push;
		logic flush;
	} bsl_cmd_t;

	typedef struct packed {
		logic chan_ok;
		logic tick;
		logic last_idx;
		logic emit;
		logic pend_valid;
		logic slot_free;
	} bsl_sts_t;

endpackage

FILE: hw/rtl/bsl_ctrl.sv
module bsl_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  bsl_pkg::bsl_sts_t sts,
	output bsl_pkg::bsl_cmd_t cmd
);
	import bsl_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_PUSH,
		ST_FLUSH
	} state_t;

	state_t state_q;
	state_t state_d;

	assign item_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					if (sts.chan_ok) state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				if (sts.emit) begin
					state_d = ST_PUSH;
				end else if (sts.tick && !sts.last_idx) begin
					cmd.advance = 1'b1;
				end else begin
					state_d = ST_FLUSH;
				end
			end
			ST_PUSH: begin
				// hold the new result until the previous one can move to the output
				if (!sts.pend_valid || sts.slot_free) begin
					cmd.push = 1'b1;
					if (sts.tick && !sts.last_idx) begin
						cmd.advance = 1'b1;
						state_d     = ST_EVAL;
					end else begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_FLUSH: begin
				if (!sts.pend_valid) begin
					state_d = ST_IDLE;
				end else if (sts.slot_free) begin
					cmd.flush = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: hw/rtl/bsl_dp.sv
module bsl_dp #(
	parameter int CHANNELS = bsl_pkg::DEF_CHANNELS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bsl_pkg::item_t                item,
	input  logic                          cfg_we,
	input  logic [bsl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bsl_pkg::CFG_W-1:0]     cfg_data,
	input  bsl_pkg::bsl_cmd_t             cmd,
	output bsl_pkg::bsl_sts_t             sts,
	output logic                          result_valid,
	input  logic                          result_stall,
	output bsl_pkg::result_t              result
);
	import bsl_pkg::*;

	localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [CFG_W-1:0] min_press_q, action_gap_q, long_press_q;

	logic [STAMP_W-1:0] now_q;
	logic [CHANNELS-1:0] held_q, ld_q, armed_q;
	logic [CHANNELS-1:0] held_d, ld_d, armed_d;
	logic [CHANNELS-1:0] ps_vld_q, la_vld_q;
	logic [STAMP_W-1:0] ps_mem [CHANNELS];
	logic [STAMP_W-1:0] la_mem [CHANNELS];
	logic [STAMP_W-1:0] ps_rd_q, la_rd_q;
	logic               ps_rd_vld_q, la_rd_vld_q;

	logic [IW-1:0]    idx_q, idx_next;
	logic             op_q, level_q;
	logic [CNT_W-1:0] cnt_q;

	logic [CHAN_W-1:0] cand_btn_q, pend_btn_q;
	logic              cand_long_q, pend_long_q;
	logic              pend_valid_q;
	logic              result_valid_q;
	result_t           result_q;

	logic [STAMP_W-1:0] ps, la, since_ps, since_la;
	logic ps_gt_min, la_gt_gap, ps_lt_long;
	logic ps_we, la_we, emit, emit_long, out_load;

	// read address follows the index that the next cycle evaluates
	always_comb begin
		if (cmd.load) begin
			idx_next = (item.op == OP_TICK) ? '0 : IW'(item.channel);
		end else if (cmd.advance) begin
			idx_next = idx_q + IW'(1);
		end else begin
			idx_next = idx_q;
		end
	end

	assign ps = ps_rd_vld_q ? ps_rd_q : '0;
	assign la = la_rd_vld_q ? la_rd_q : '0;
	assign since_ps   = now_q - ps;
	assign since_la   = now_q - la;
	assign ps_gt_min  = since_ps > STAMP_W'(min_press_q);
	assign la_gt_gap  = since_la > STAMP_W'(action_gap_q);
	assign ps_lt_long = since_ps < STAMP_W'(long_press_q);

	always_comb begin
		held_d    = held_q;
		ld_d      = ld_q;
		armed_d   = armed_q;
		ps_we     = 1'b0;
		la_we     = 1'b0;
		emit      = 1'b0;
		emit_long = 1'b0;
		if (op_q == OP_LEVEL) begin
			if (level_q == LEVEL_PRESSED) begin
				if (!held_q[idx_q]) begin
					held_d[idx_q] = 1'b1;
					// a press too soon after the last one marks held but keeps the stamp
					if (ps_gt_min) begin
						ps_we          = 1'b1;
						ld_d[idx_q]    = 1'b0;
						armed_d[idx_q] = 1'b1;
					end
				end
			end else if (held_q[idx_q]) begin
				held_d[idx_q] = 1'b0;
				if (ps_gt_min && la_gt_gap) begin
					la_we = 1'b1;
					if (ps_lt_long) begin
						emit = 1'b1;
					end else if (!ld_q[idx_q]) begin
						ld_d[idx_q] = 1'b1;
						emit        = 1'b1;
						emit_long   = 1'b1;
					end
				end
			end
		end else if (armed_q[idx_q] && !ps_lt_long) begin
			armed_d[idx_q] = 1'b0;
			if (held_q[idx_q] && !ld_q[idx_q] && la_gt_gap &&
			    cnt_q < CNT_W'(MAX_RESULTS)) begin
				la_we          = 1'b1;
				ld_d[idx_q]    = 1'b1;
				held_d[idx_q]  = 1'b0;
				emit           = 1'b1;
				emit_long      = 1'b1;
			end
		end
	end

	assign out_load = (cmd.push && pend_valid_q) || cmd.flush;

	always_comb begin
		sts            = '0;
		sts.chan_ok    = (item.op == OP_TICK) || (32'(item.channel) < 32'(CHANNELS));
		sts.tick       = (op_q == OP_TICK);
		sts.last_idx   = (idx_q == IW'(CHANNELS - 1));
		sts.emit       = emit;
		sts.pend_valid = pend_valid_q;
		sts.slot_free  = !result_valid_q || !result_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_press_q    <= RST_MIN_PRESS;
			action_gap_q   <= RST_ACTION_GAP;
			long_press_q   <= RST_LONG_PRESS;
			now_q          <= '0;
			held_q         <= '0;
			ld_q           <= '1;
			armed_q        <= '0;
			ps_vld_q       <= '0;
			la_vld_q       <= '0;
			ps_rd_vld_q    <= 1'b0;
			la_rd_vld_q    <= 1'b0;
			idx_q          <= '0;
			op_q           <= OP_LEVEL;
			level_q        <= 1'b1;
			cnt_q          <= '0;
			pend_valid_q   <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MIN_PRESS:  min_press_q  <= cfg_data;
					REG_ACTION_GAP: action_gap_q <= cfg_data;
					REG_LONG_PRESS: long_press_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load) begin
				op_q    <= item.op;
				level_q <= item.level;
				cnt_q   <= '0;
				if (item.op == OP_TICK) now_q <= now_q + STAMP_W'(1);
			end else if (cmd.eval && emit) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			idx_q       <= idx_next;
			ps_rd_vld_q <= ps_vld_q[idx_next];
			la_rd_vld_q <= la_vld_q[idx_next];
			if (cmd.eval) begin
				held_q  <= held_d;
				ld_q    <= ld_d;
				armed_q <= armed_d;
				if (ps_we) ps_vld_q[idx_q] <= 1'b1;
				if (la_we) la_vld_q[idx_q] <= 1'b1;
			end
			if (cmd.push) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// stamp stores and result payload
	always_ff @(posedge clk) begin
		if (cmd.eval && ps_we) ps_mem[idx_q] <= now_q;
		if (cmd.eval && la_we) la_mem[idx_q] <= now_q;
		ps_rd_q <= ps_mem[idx_next];
		la_rd_q <= la_mem[idx_next];
		if (cmd.eval && emit) begin
			cand_btn_q  <= CHAN_W'(idx_q);
			cand_long_q <= emit_long;
		end
		if (cmd.push) begin
			pend_btn_q  <= cand_btn_q;
			pend_long_q <= cand_long_q;
		end
		if (out_load) begin
			result_q.button  <= pend_btn_q;
			result_q.is_long <= pend_long_q;
			result_q.last    <= cmd.flush;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

FILE: hw/rtl/button_short_long_press_classifier.sv
// Classifies button presses on up to CHANNELS channels as short or long. A request is
// either a level change on one channel (low = pressed) or a one-millisecond tick; the
// millisecond count advances on ticks only and stamps the presses and actions it accepts.
// A tick scans the channels one per cycle, pausing for each long press found and while
// the result side stalls, through a single read port of the stamp stores. Results leave
// through an output register, and the final result of a request carries last. New
// requests are taken once the previous request has handed its last result to that
// register. The configuration port is always ready; write it only while the block is idle.
module button_short_long_press_classifier #(
	parameter int CHANNELS = bsl_pkg::DEF_CHANNELS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  bsl_pkg::item_t                item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output bsl_pkg::result_t              result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bsl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bsl_pkg::CFG_W-1:0]     cfg_data
);
	import bsl_pkg::*;

	bsl_cmd_t cmd;
	bsl_sts_t sts;

	assign cfg_ready = 1'b1;

	bsl_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	bsl_dp #(
		.CHANNELS (CHANNELS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// nothing may stay pending once the block takes a new request
	assert property (@(posedge clk) disable iff (!arst_n)
		!item_stall |-> !sts.pend_valid)
		else $error("pending result left behind at request accept");

	// a pending result only moves out when the output register can take it
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push && sts.pend_valid) || cmd.flush |-> sts.slot_free)
		else $error("result overwrote an undelivered output");

	// the scan advances only during a tick and never past the last channel
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance |-> sts.tick && !sts.last_idx)
		else $error("scan advanced outside a tick");

	// a flushed result always shows valid and marked last on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> result_valid && result.last)
		else $error("final result not presented");

endmodule
